// File: hdl/multichannel_boxcar_decimator_defines.svh
// Assertion macros shared by the decimator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MULTICHANNEL_BOXCAR_DECIMATOR_DEFINES_SVH
`define MULTICHANNEL_BOXCAR_DECIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbd: same-cycle check failed");
// next-cycle implication
`define MBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbd: next-cycle check failed");
`else
`define MBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/mbd_pkg.sv
// Shared constants, types and helpers for the boxcar decimator.
// No dependencies; imported by mbd_seq and the top level of the block.
package mbd_pkg;

    localparam int MAX_CHANNELS   = 32;
    localparam int MAX_OVERSAMPLE = 256;

    localparam int WORD_W     = 32;
    localparam int NARROW_W   = 16;
    localparam int CH_W       = $clog2(MAX_CHANNELS);
    localparam int SCAN_W     = $clog2(MAX_OVERSAMPLE);
    localparam int SHIFT_W    = $clog2(SCAN_W + 1);
    localparam int NCH_CFG_W  = 6;
    localparam int OVER_CFG_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [NCH_CFG_W-1:0]  NCH_RESET    = NCH_CFG_W'(4);
    localparam logic [OVER_CFG_W-1:0] OVER_RESET   = OVER_CFG_W'(1);
    localparam logic                  NARROW_RESET = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 2'd0,
        REG_OVERSAMPLE    = 2'd1,
        REG_NARROW_WORDS  = 2'd2
    } t_reg_idx;

    // per-item control from the sequencer
    typedef struct packed {
        logic [CH_W-1:0] idx;
        logic            last_ch;
        logic            last_scan;
        logic            clear;
    } t_item_ctl;

    // settings seen by the datapath
    typedef struct packed {
        logic               narrow;
        logic [SHIFT_W-1:0] shift;
    } t_cfg;

    // smallest s with 2^s >= over (over already clamped to 1..MAX_OVERSAMPLE)
    function automatic logic [SHIFT_W-1:0] shift_for(input logic [OVER_CFG_W-1:0] over);
        logic [SHIFT_W-1:0]    res;
        logic [OVER_CFG_W-1:0] pw;
        res = SHIFT_W'(SCAN_W);
        for (int s = SCAN_W; s >= 0; s--) begin
            pw = OVER_CFG_W'(1) << s;
            if (pw >= over) begin
                res = SHIFT_W'(s);
            end
        end
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] sext_narrow(input logic [WORD_W-1:0] v);
        return {{(WORD_W-NARROW_W){v[NARROW_W-1]}}, v[NARROW_W-1:0]};
    endfunction

endpackage

// File: hdl/mbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the per-channel sums of the decimator.
module mbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read during write to the same address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/mbd_seq.sv
// Configuration registers and the channel / scan sequencer.
// Depends on mbd_pkg; feeds per-item control to the accumulator datapath.
module mbd_seq
    import mbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic                  i_buffer_start,
    output t_item_ctl             o_ctl,
    output t_cfg                  o_cfg
);

    logic [NCH_CFG_W-1:0]  r_nch;
    logic [OVER_CFG_W-1:0] r_over;
    logic                  r_narrow;
    logic [CH_W-1:0]       r_chan_idx, n_chan_idx;
    logic [SCAN_W-1:0]     r_scans, n_scans;

    logic [NCH_CFG_W-1:0]  nch_eff;
    logic [OVER_CFG_W-1:0] over_eff;
    logic [CH_W-1:0]       idx;
    logic [SCAN_W-1:0]     scans;
    logic                  last_ch, last_scan;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nch    <= NCH_RESET;
            r_over   <= OVER_RESET;
            r_narrow <= NARROW_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CHANNEL_COUNT: r_nch    <= i_cfg_data[NCH_CFG_W-1:0];
                REG_OVERSAMPLE:    r_over   <= i_cfg_data[OVER_CFG_W-1:0];
                REG_NARROW_WORDS:  r_narrow <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp the settings to their legal ranges
    always_comb begin
        nch_eff = r_nch;
        if (r_nch == '0) begin
            nch_eff = NCH_CFG_W'(1);
        end else if (r_nch > NCH_CFG_W'(MAX_CHANNELS)) begin
            nch_eff = NCH_CFG_W'(MAX_CHANNELS);
        end
        over_eff = r_over;
        if (r_over == '0) begin
            over_eff = OVER_CFG_W'(1);
        end else if (r_over > OVER_CFG_W'(MAX_OVERSAMPLE)) begin
            over_eff = OVER_CFG_W'(MAX_OVERSAMPLE);
        end
    end

    // buffer start restarts the scan at channel zero
    assign idx   = i_buffer_start ? '0 : r_chan_idx;
    assign scans = i_buffer_start ? '0 : r_scans;

    // index past the count (count lowered mid-scan) also ends the scan
    assign last_ch   = ((NCH_CFG_W+1)'(idx) + 1'b1) >= (NCH_CFG_W+1)'(nch_eff);
    assign last_scan = ((OVER_CFG_W+1)'(scans) + 1'b1) >= (OVER_CFG_W+1)'(over_eff);

    always_comb begin
        n_chan_idx = r_chan_idx;
        n_scans    = r_scans;
        if (i_accept) begin
            if (last_ch) begin
                n_chan_idx = '0;
                n_scans    = last_scan ? '0 : scans + 1'b1;
            end else begin
                n_chan_idx = idx + 1'b1;
                n_scans    = scans;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_idx <= '0;
            r_scans    <= '0;
        end else begin
            r_chan_idx <= n_chan_idx;
            r_scans    <= n_scans;
        end
    end

    assign o_ctl = '{idx: idx, last_ch: last_ch, last_scan: last_scan, clear: i_buffer_start};
    assign o_cfg = '{narrow: r_narrow, shift: shift_for(over_eff)};

endmodule

// File: hdl/multichannel_boxcar_decimator.sv
// Multichannel boxcar decimator: top level with the accumulate stage.
// Depends on mbd_pkg, mbd_seq, mbd_ram and the assertion macro header.
//
// Accumulate-and-dump decimator for channel-interleaved ADC words. Each
// accepted word is added to a 32-bit wrapping sum kept for its channel;
// during the last scan of a group of oversample_factor scans each channel's
// sum is shifted right arithmetically by ceil(log2(oversample_factor)),
// handed out with its channel number (tlast on the last channel of the
// scan) and cleared. In narrow mode words are sign-extended from bit 15
// and results truncated to 16 bits and sign-extended. tuser on the input
// (buffer start) drops all partial sums and restarts at channel 0, scan 0.
// Rate: one word per clock, sustained; a word's result is registered in
// the accumulate stage and then in the output register. The figure is set
// by the sum RAM: one read and one write-back per word, the read issued on
// acceptance and the write done as the word leaves the accumulate stage,
// with a bypass register covering a word that hits the channel being
// written (single channel operation). Input stalls only when a result is
// due and the output register is still held by the downstream side. Sums
// are cleared through per-channel valid flags, so there is no clearing
// pass after reset or buffer start. Configuration writes are taken every
// cycle and must only be made while the block is idle.
`include "multichannel_boxcar_decimator_defines.svh"

module multichannel_boxcar_decimator
    import mbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [WORD_W-1:0]     i_s_axis_tdata,   // [31:0] sample
    input  logic                  i_s_axis_tuser,   // [0] buffer_start
    // output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [WORD_W-1:0]     o_m_axis_tdata,   // [31:0] value
    output logic [CH_W-1:0]       o_m_axis_tuser,   // [4:0] channel
    output logic                  o_m_axis_tlast,   // scan_last
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_item_ctl item_ctl;
    t_cfg      cfg;

    logic              s_accept;
    logic [WORD_W-1:0] x_in;

    // accumulate stage (word whose sum is being read back)
    logic              r_s1_vld;
    logic [WORD_W-1:0] r_s1_x;
    logic [CH_W-1:0]   r_s1_idx;
    logic              r_s1_last_ch;
    logic              r_s1_last_scan;
    logic              r_s1_zero;      // start from zero: cleared or never written
    logic              r_byp;          // RAM word is stale, use r_byp_data
    logic [WORD_W-1:0] r_byp_data;

    logic [MAX_CHANNELS-1:0] r_valid, n_valid;

    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] s1_base, s1_sum, s1_shifted, s1_value;
    logic              s1_go, out_free, wr_en, same_entry, valid_eff;
    logic [WORD_W-1:0] wr_data;

    // output register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_value;
    logic [CH_W-1:0]   r_out_channel;
    logic              r_out_last;

    mbd_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (s_accept),
        .i_buffer_start (i_s_axis_tuser),
        .o_ctl          (item_ctl),
        .o_cfg          (cfg)
    );

    mbd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_CHANNELS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_idx),
        .i_wdata (wr_data),
        .i_re    (s_accept),
        .i_raddr (item_ctl.idx),
        .o_rdata (ram_rdata)
    );

    // handshakes: the stage moves on unless its result finds the output full
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_go           = r_s1_vld && (!r_s1_last_scan || out_free);
    assign o_s_axis_tready = !r_s1_vld || s1_go;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign x_in = cfg.narrow ? sext_narrow(i_s_axis_tdata) : i_s_axis_tdata;

    // read-modify-write datapath
    always_comb begin
        if (r_s1_zero) begin
            s1_base = '0;
        end else if (r_byp) begin
            s1_base = r_byp_data;
        end else begin
            s1_base = ram_rdata;
        end
        s1_sum     = s1_base + r_s1_x;
        s1_shifted = WORD_W'($signed(s1_sum) >>> cfg.shift);
        s1_value   = cfg.narrow ? sext_narrow(s1_shifted) : s1_shifted;
        wr_en      = s1_go;
        wr_data    = r_s1_last_scan ? '0 : s1_sum;
        // word taken while the older word writes the same channel
        same_entry = s1_go && (r_s1_idx == item_ctl.idx);
        valid_eff  = r_valid[item_ctl.idx] || same_entry;
    end

    // valid flags: set on write-back, all dropped by buffer start
    always_comb begin
        n_valid = r_valid;
        if (wr_en) begin
            n_valid[r_s1_idx] = 1'b1;
        end
        if (s_accept && item_ctl.clear) begin
            n_valid = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_s1_vld <= 1'b0;
            r_byp    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (s_accept) begin
                r_s1_vld <= 1'b1;
                r_byp    <= same_entry && !item_ctl.clear;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
                r_byp    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_x         <= x_in;
            r_s1_idx       <= item_ctl.idx;
            r_s1_last_ch   <= item_ctl.last_ch;
            r_s1_last_scan <= item_ctl.last_scan;
            r_s1_zero      <= item_ctl.clear || !valid_eff;
            r_byp_data     <= wr_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last_scan) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last_scan) begin
            r_out_value   <= s1_value;
            r_out_channel <= r_s1_idx;
            r_out_last    <= r_s1_last_ch;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_channel;
    assign o_m_axis_tlast  = r_out_last;

    // a stalled word keeps its channel and addend
    `MBD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_s1_vld && !s1_go, r_s1_vld && $stable(r_s1_idx) && $stable(r_s1_x))
    // the bypass word only lives alongside a word in the stage
    `MBD_ASSERT_IMP(a_byp_live, i_clk, i_rst_n, r_byp, r_s1_vld)
    // a hit on the channel being written picks up the written sum
    `MBD_ASSERT_NEXT(a_byp_set, i_clk, i_rst_n, s_accept && same_entry && !item_ctl.clear, r_byp && (r_byp_data == $past(wr_data)))
    // buffer start: the word's sum starts from zero
    `MBD_ASSERT_NEXT(a_clear, i_clk, i_rst_n, s_accept && item_ctl.clear, r_s1_zero && !r_byp)

endmodule

// File: bench/multichannel_boxcar_decimator_test.sv
// Self-checking bench for the multichannel boxcar decimator: directed corner cases,
// then random streams under random configuration, with gaps and stalls on both streams.
// Depends on mbd_pkg and the multichannel_boxcar_decimator RTL only.
module multichannel_boxcar_decimator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mbd_pkg::*;

    // register index that decodes to nothing; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    // cycles allowed after the last expected item before touching the registers
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [CH_W-1:0]   channel;
        logic              scan_last;
    } t_dec_out;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [WORD_W-1:0]     i_s_axis_tdata;
    logic                  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [WORD_W-1:0]     o_m_axis_tdata;
    logic [CH_W-1:0]       o_m_axis_tuser;
    logic                  o_m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    multichannel_boxcar_decimator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // ---------------------------------------------------------------
    // Predictor state: our own copy of the sums, position and settings
    // ---------------------------------------------------------------
    logic [WORD_W-1:0]     acc [MAX_CHANNELS];
    int unsigned           ch_pos;
    int unsigned           scans_done;
    logic [NCH_CFG_W-1:0]  cfg_channels;
    logic [OVER_CFG_W-1:0] cfg_oversample;
    logic                  cfg_narrow;

    t_dec_out due_values[$];   // decimated values still owed by the block
    t_dec_out want;
    int       mismatches;

    // idling controls, switched per test
    bit src_gaps;
    bit sink_stalls;
    int hold_left;

    // ---------------------------------------------------------------
    // Clock and watchdog
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor: one accepted word in, at most one decimated value out
    // ---------------------------------------------------------------
    function automatic void decimate_word(input logic [WORD_W-1:0] sample, input logic start);
        int unsigned       n_ch;
        int unsigned       n_over;
        int unsigned       pos;
        int unsigned       sh;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] v;
        logic              end_ch;
        logic              end_scan;
        t_dec_out          r;
        // zero settings act as 1, oversized ones saturate
        n_ch   = (cfg_channels == 0) ? 1 :
                 (cfg_channels > MAX_CHANNELS) ? MAX_CHANNELS : cfg_channels;
        n_over = (cfg_oversample == 0) ? 1 :
                 (cfg_oversample > MAX_OVERSAMPLE) ? MAX_OVERSAMPLE : cfg_oversample;
        if (start) begin
            foreach (acc[i]) acc[i] = '0;
            ch_pos     = 0;
            scans_done = 0;
        end
        word = cfg_narrow ? {{(WORD_W-NARROW_W){sample[NARROW_W-1]}}, sample[NARROW_W-1:0]}
                          : sample;
        pos = (ch_pos >= MAX_CHANNELS) ? MAX_CHANNELS - 1 : ch_pos;
        // index or scan count beyond a lowered setting closes the scan / group
        end_ch   = (pos + 1 >= n_ch);
        end_scan = (scans_done + 1 >= n_over);
        acc[pos] = acc[pos] + word;
        if (end_scan) begin
            sh = 0;
            while (sh < 31 && (1 << sh) < n_over) sh++;
            v = $signed(acc[pos]) >>> sh;
            if (cfg_narrow) v = {{(WORD_W-NARROW_W){v[NARROW_W-1]}}, v[NARROW_W-1:0]};
            acc[pos]    = '0;
            r.value     = v;
            r.channel   = CH_W'(pos);
            r.scan_last = end_ch;
            due_values.push_back(r);
        end
        if (end_ch) begin
            ch_pos     = 0;
            scans_done = end_scan ? 0 : scans_done + 1;
        end else begin
            ch_pos = pos + 1;
        end
    endfunction

    // mostly no gap, some short ones, a few long
    function automatic int unsigned pick_gap(input bit at_least_one);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12 && !at_least_one) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [WORD_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                       $urandom_range(0, 1) ? 16'h7FFF : 16'h8000};
            default: return $urandom();
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Output side: random back-pressure and the result checker
    // ---------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                hold_left = pick_gap(1'b1) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (due_values.size() == 0) begin
                $error("unexpected output item: value %h channel %0d last %b",
                       o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                mismatches++;
            end else begin
                want = due_values.pop_front();
                if (o_m_axis_tdata !== want.value) begin
                    $error("value: expected %h, got %h", want.value, o_m_axis_tdata);
                    mismatches++;
                end
                if (o_m_axis_tuser !== want.channel) begin
                    $error("channel: expected %0d, got %0d", want.channel, o_m_axis_tuser);
                    mismatches++;
                end
                if (o_m_axis_tlast !== want.scan_last) begin
                    $error("scan_last: expected %b, got %b", want.scan_last, o_m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side helpers; all called right after a rising edge
    // ---------------------------------------------------------------
    task automatic send_item(input logic [WORD_W-1:0] sample, input logic start);
        int unsigned gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= sample;
        i_s_axis_tuser  <= start;
        do @(posedge i_clk); while (!o_s_axis_tready);
        decimate_word(sample, start);
        gap = src_gaps ? pick_gap(1'b0) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending, let every owed item drain, then allow the pipe to empty
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (due_values.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_CHANNEL_COUNT: cfg_channels   = data[NCH_CFG_W-1:0];
            REG_OVERSAMPLE:    cfg_oversample = data[OVER_CFG_W-1:0];
            REG_NARROW_WORDS:  cfg_narrow     = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // reset settings: 4 channels, no decimation, 16-bit words
    task automatic test_reset_settings();
        src_gaps    = 1;
        sink_stalls = 1;
        send_item(32'h0000_7FFF, 1'b1);
        send_item(32'h0000_8000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h1234_0001, 1'b0);   // upper half ignored
        settle();
    endtask

    // 32-bit words: sums wrap, shift rounds the factor up to a power of two
    task automatic test_wide_wrap();
        write_reg(REG_NARROW_WORDS, 9'd0);
        write_reg(REG_CHANNEL_COUNT, 9'd1);
        write_reg(REG_OVERSAMPLE, 9'd3);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        settle();
        write_reg(REG_OVERSAMPLE, 9'd2);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        settle();
    endtask

    // zero settings behave as one; unused index leaves everything alone
    task automatic test_zero_and_unused();
        write_reg(REG_CHANNEL_COUNT, 9'd0);
        write_reg(REG_OVERSAMPLE, 9'd0);
        send_item(32'hDEAD_BEEF, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        settle();
        write_reg(REG_UNUSED, 9'h1FF);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'hFFFF_FFFE, 1'b0);
        settle();
    endtask

    // settings lowered while a scan or group is half done
    task automatic test_shrink_mid_scan();
        write_reg(REG_NARROW_WORDS, 9'd1);
        write_reg(REG_CHANNEL_COUNT, 9'd6);
        write_reg(REG_OVERSAMPLE, 9'd1);
        repeat (3) send_item($urandom(), 1'b0);
        settle();
        write_reg(REG_CHANNEL_COUNT, 9'd2);   // index 3 now closes the scan
        repeat (2) send_item($urandom(), 1'b0);
        settle();
        write_reg(REG_OVERSAMPLE, 9'd4);
        repeat (4) send_item($urandom(), 1'b0);
        settle();
        write_reg(REG_OVERSAMPLE, 9'd2);      // scan count already past the factor
        repeat (2) send_item($urandom(), 1'b0);
        settle();
    endtask

    // buffer start mid-group throws the partial sums away
    task automatic test_buffer_start();
        repeat (3) send_item($urandom(), 1'b0);
        send_item($urandom(), 1'b1);
        repeat (3) send_item($urandom(), 1'b0);
        settle();
    endtask

    // widest channel count and the largest factor, saturated from above
    task automatic test_extreme_settings();
        src_gaps    = 0;
        sink_stalls = 0;
        write_reg(REG_NARROW_WORDS, 9'd0);
        write_reg(REG_CHANNEL_COUNT, 9'd63);
        write_reg(REG_OVERSAMPLE, 9'd1);
        send_item(rand_sample(), 1'b1);
        repeat (39) send_item(rand_sample(), 1'b0);
        settle();
        src_gaps    = 1;
        sink_stalls = 1;
        write_reg(REG_CHANNEL_COUNT, 9'd1);
        write_reg(REG_OVERSAMPLE, 9'd511);
        send_item(rand_sample(), 1'b1);
        repeat (259) send_item(rand_sample(), 1'b0);
        settle();
    endtask

    // random phases: small settings mostly, now and then anything the fields allow
    task automatic test_random_streams();
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < 450) begin
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            write_reg(REG_CHANNEL_COUNT,
                      CFG_DATA_W'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 8)
                                                             : $urandom_range(0, 63)));
            case ($urandom_range(0, 9))
                9:       write_reg(REG_OVERSAMPLE, CFG_DATA_W'($urandom_range(0, 511)));
                8:       write_reg(REG_OVERSAMPLE, CFG_DATA_W'($urandom_range(0, 16)));
                default: write_reg(REG_OVERSAMPLE, CFG_DATA_W'($urandom_range(1, 6)));
            endcase
            write_reg(REG_NARROW_WORDS, CFG_DATA_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0) begin
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 511)));
            end
            burst = $urandom_range(20, 80);
            // the state carries over between phases, so reconfiguration mid-scan
            // comes up as well
            repeat (burst) send_item(rand_sample(), $urandom_range(0, 39) == 0);
            sent += burst;
            settle();
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        mismatches      = 0;
        hold_left       = 0;
        src_gaps        = 0;
        sink_stalls     = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_CHANNEL_COUNT;
        i_cfg_data      = '0;
        foreach (acc[i]) acc[i] = '0;
        ch_pos          = 0;
        scans_done      = 0;
        cfg_channels    = NCH_RESET;
        cfg_oversample  = OVER_RESET;
        cfg_narrow      = NARROW_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_wide_wrap();
        test_zero_and_unused();
        test_shrink_mid_scan();
        test_buffer_start();
        test_extreme_settings();
        test_random_streams();
        settle();

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/mbd_pkg.sv
hdl/mbd_ram.sv
hdl/mbd_seq.sv
hdl/multichannel_boxcar_decimator.sv
bench/multichannel_boxcar_decimator_test.sv
